@@ rtl/glyph_row_double_scale_blitter_unit_defines.svh @@
// Assertion macros shared by the glyph row blitter.
`ifndef GLYPH_ROW_DOUBLE_SCALE_BLITTER_UNIT_DEFINES_SVH
`define GLYPH_ROW_DOUBLE_SCALE_BLITTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define GDSB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GDSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gdsb_pkg.sv @@
// Package with constants, types and state codes of the glyph row blitter.
package gdsb_pkg;

    localparam int GLYPH_COLS  = 8;
    localparam int COORD_BITS  = 12;
    localparam int ROW_BITS    = 3;
    localparam int COLOR_BITS  = 24;
    localparam int ADDR_BITS   = 32;
    localparam int PITCH_BITS  = 13;
    localparam int COL_BITS    = $clog2(GLYPH_COLS);
    localparam int PX_BITS     = COORD_BITS + 1;
    localparam int PY_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS   = PY_BITS + PITCH_BITS;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(1080);
    localparam logic [7:0]            ALPHA_BYTE  = 8'hff;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_BASE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_PITCH = CFG_IDX_BITS'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_LINE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic line;
        logic emit;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic in_nonzero;
        logic cur_bit;
        logic rest_zero;
        logic quad_last;
        logic out_free;
    } status_t;

endpackage

@@ rtl/gdsb_ctrl.sv @@
// Controller state machine of the glyph row blitter.
module gdsb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  gdsb_pkg::status_t status,
    output gdsb_pkg::cmd_t    cmd,
    output logic              busy
);
    import gdsb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.in_nonzero)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_LINE;
            end
            ST_LINE:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.out_free && status.cur_bit && status.quad_last && status.rest_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = in_valid;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_LINE:
            begin
                cmd.line = 1'b1;
            end
            ST_SCAN:
            begin
                if (status.cur_bit)
                begin
                    cmd.emit    = status.out_free;
                    cmd.advance = status.out_free && status.quad_last;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
        endcase
    end

endmodule

@@ rtl/gdsb_datapath.sv @@
// Datapath of the glyph row blitter: registers, address arithmetic and output register.
module gdsb_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  gdsb_pkg::cmd_t                        cmd,
    output gdsb_pkg::status_t                     status,
    input  logic                                  cfg_valid,
    input  logic [gdsb_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [gdsb_pkg::ADDR_BITS-1:0]        cfg_data,
    input  logic [gdsb_pkg::GLYPH_COLS-1:0]       glyph_bits,
    input  logic [gdsb_pkg::ROW_BITS-1:0]         row_index,
    input  logic [gdsb_pkg::COORD_BITS-1:0]       cell_x,
    input  logic [gdsb_pkg::COORD_BITS-1:0]       cell_y,
    input  logic [gdsb_pkg::COLOR_BITS-1:0]       color,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [gdsb_pkg::ADDR_BITS-1:0]        write_addr,
    output logic [gdsb_pkg::ADDR_BITS-1:0]        write_data,
    output logic                                  last_write
);
    import gdsb_pkg::*;

    logic [ADDR_BITS-1:0]  frame_base_reg;
    logic [PITCH_BITS-1:0] line_pitch_reg;

    logic [GLYPH_COLS-1:0] pending_reg;
    logic [COL_BITS-1:0]   col_reg;
    logic [1:0]            quad_reg;
    logic [ROW_BITS-1:0]   row_reg;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [ADDR_BITS-1:0]  line0_reg;
    logic [ADDR_BITS-1:0]  line1_reg;

    logic                  out_valid_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [ADDR_BITS-1:0]  data_reg;
    logic                  last_reg;

    logic [PY_BITS-1:0]    py0;
    logic [PROD_BITS:0]    prod1;
    logic [PX_BITS-1:0]    px;
    logic [ADDR_BITS-1:0]  addr_next;

    assign py0   = PY_BITS'(cy_reg) + PY_BITS'({row_reg, 1'b0});
    assign prod1 = {1'b0, prod_reg} + (PROD_BITS + 1)'(line_pitch_reg);
    assign px    = PX_BITS'(cx_reg) + PX_BITS'({col_reg, quad_reg[0]});
    assign addr_next = (quad_reg[1] ? line1_reg : line0_reg) + ADDR_BITS'({px, 2'b00});

    assign status.in_nonzero = (glyph_bits != '0);
    assign status.cur_bit    = pending_reg[GLYPH_COLS-1];
    assign status.rest_zero  = (pending_reg[GLYPH_COLS-2:0] == '0);
    assign status.quad_last  = (quad_reg == 2'd3);
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= '0;
            line_pitch_reg <= PITCH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_BASE: frame_base_reg <= cfg_data;
                REG_LINE_PITCH: line_pitch_reg <= cfg_data[PITCH_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            col_reg     <= '0;
            quad_reg    <= '0;
        end
        else if (cmd.load)
        begin
            pending_reg <= glyph_bits;
            col_reg     <= '0;
            quad_reg    <= '0;
        end
        else if (cmd.advance)
        begin
            pending_reg <= {pending_reg[GLYPH_COLS-2:0], 1'b0};
            col_reg     <= col_reg + COL_BITS'(1);
            quad_reg    <= '0;
        end
        else if (cmd.emit)
        begin
            quad_reg <= quad_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_reg   <= row_index;
            cx_reg    <= cell_x;
            cy_reg    <= cell_y;
            color_reg <= color;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_BITS'(py0) * PROD_BITS'(line_pitch_reg);
        end
        if (cmd.line)
        begin
            line0_reg <= frame_base_reg + ADDR_BITS'({prod_reg, 2'b00});
            line1_reg <= frame_base_reg + ADDR_BITS'({prod1, 2'b00});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            addr_reg <= addr_next;
            data_reg <= {ALPHA_BYTE, color_reg};
            last_reg <= status.quad_last && status.rest_zero;
        end
    end

    assign out_valid  = out_valid_reg;
    assign write_addr = addr_reg;
    assign write_data = data_reg;
    assign last_write = last_reg;

endmodule

@@ rtl/glyph_row_double_scale_blitter_unit.sv @@
// Top level of the glyph row blitter: controller, datapath and assertions.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    glyph_bits, row_index, cell_x, cell_y, color
// out       output     out_valid / out_stall  write_addr, write_data, last_write
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An all-zero row is accepted without leaving idle and produces nothing.
// Any other row passes through ST_MUL for the row multiply and ST_LINE for the line
// addresses, then ST_SCAN skips clear columns before the last set bit and emits four
// writes per set bit, so a full row of eight set bits produces 32 writes.
// Reset clears all control state and loads a pitch of 1080 and a base of zero.
// A stalled output transaction holds the scan at the next set bit until the write is taken.
module glyph_row_double_scale_blitter_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [gdsb_pkg::GLYPH_COLS-1:0]       glyph_bits,
    input  logic [gdsb_pkg::ROW_BITS-1:0]         row_index,
    input  logic [gdsb_pkg::COORD_BITS-1:0]       cell_x,
    input  logic [gdsb_pkg::COORD_BITS-1:0]       cell_y,
    input  logic [gdsb_pkg::COLOR_BITS-1:0]       color,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [gdsb_pkg::ADDR_BITS-1:0]        write_addr,
    output logic [gdsb_pkg::ADDR_BITS-1:0]        write_data,
    output logic                                  last_write,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gdsb_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [gdsb_pkg::ADDR_BITS-1:0]        cfg_data
);
    import gdsb_pkg::*;

    `include "glyph_row_double_scale_blitter_unit_defines.svh"

    cmd_t    cmd;
    status_t status;
    logic    busy;

    assign in_stall  = busy;
    assign cfg_ready = 1'b1;

    gdsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    gdsb_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .glyph_bits (glyph_bits),
        .row_index  (row_index),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .color      (color),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .write_addr (write_addr),
        .write_data (write_data),
        .last_write (last_write)
    );

    `GDSB_ASSERT_NEXT(a_empty_row_idle, in_valid && !in_stall && glyph_bits == '0, !in_stall, "Empty row left the block busy.")
    `GDSB_ASSERT_NEXT(a_row_busy, in_valid && !in_stall && glyph_bits != '0, in_stall, "Nonempty row did not start a scan.")
    `GDSB_ASSERT_NOW(a_mid_row_busy, out_valid && !last_write, in_stall, "Row ended without a final write.")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the double-scale glyph row blitter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gdsb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 22;

    typedef struct packed {
        logic [GLYPH_COLS-1:0] bits;
        logic [ROW_BITS-1:0]   row;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COLOR_BITS-1:0] color;
    } glyph_row_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] data;
        logic                 last;
    } pixel_write_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [GLYPH_COLS-1:0]   glyph_bits = '0;
    logic [ROW_BITS-1:0]     row_index = '0;
    logic [COORD_BITS-1:0]   cell_x = '0;
    logic [COORD_BITS-1:0]   cell_y = '0;
    logic [COLOR_BITS-1:0]   color = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [ADDR_BITS-1:0]    write_addr;
    logic [ADDR_BITS-1:0]    write_data;
    logic                    last_write;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [ADDR_BITS-1:0]    cfg_data = '0;

    glyph_row_t   pending_rows_q[$];
    pixel_write_t pixel_writes_q[$];

    logic [ADDR_BITS-1:0]  fb_base = '0;
    logic [PITCH_BITS-1:0] fb_pitch = PITCH_RESET;

    bit calm = 1'b0;
    bit hold_request = 1'b0;
    bit in_slot_free = 1'b1;
    int hold_left = 0;
    int fails = 0;
    int cycles = 0;

    glyph_row_double_scale_blitter_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .glyph_bits (glyph_bits),
        .row_index  (row_index),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .color      (color),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .write_addr (write_addr),
        .write_data (write_data),
        .last_write (last_write),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic void predict_pixel_writes(glyph_row_t r);
        pixel_write_t w;
        logic [31:0]  px;
        logic [31:0]  py;
        logic [31:0]  offset;
        logic [7:0]   rest;
        for (int c = 0; c < GLYPH_COLS; c++)
        begin
            if (r.bits[GLYPH_COLS-1-c])
            begin
                rest = r.bits & ((8'd1 << (GLYPH_COLS - 1 - c)) - 8'd1);
                for (int q = 0; q < 4; q++)
                begin
                    px = 32'(r.cx) + 32'(2 * c) + 32'(q & 1);
                    py = 32'(r.cy) + 32'(2 * r.row) + 32'((q >> 1) & 1);
                    offset = px + py * 32'(fb_pitch);
                    w.addr = fb_base + (offset << 2);
                    w.data = {ALPHA_BYTE, r.color};
                    w.last = (q == 3) && (rest == 8'd0);
                    pixel_writes_q.push_back(w);
                end
            end
        end
    endfunction

    function automatic glyph_row_t random_row();
        glyph_row_t r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 12)
            r.bits = 8'h00;
        else if (pick < 22)
            r.bits = 8'hff;
        else
            r.bits = 8'($urandom);
        r.row = 3'($urandom_range(7));
        r.cx = 12'($urandom);
        r.cy = 12'($urandom);
        r.color = 24'($urandom);
        return r;
    endfunction

    task automatic add_row(input logic [7:0] bits, input logic [2:0] row,
                           input logic [11:0] cx, input logic [11:0] cy,
                           input logic [23:0] rgb);
        glyph_row_t r;
        r.bits = bits;
        r.row = row;
        r.cx = cx;
        r.cy = cy;
        r.color = rgb;
        pending_rows_q.push_back(r);
    endtask

    task automatic wait_for_drain();
        while (pending_rows_q.size() > 0 || !in_slot_free || in_valid
               || pixel_writes_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [ADDR_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_FRAME_BASE)
            fb_base = value;
        else if (idx == REG_LINE_PITCH)
            fb_pitch = value[PITCH_BITS-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_pixel_writes({glyph_bits, row_index, cell_x, cell_y, color});
            in_slot_free = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        glyph_row_t r;
        if (rst_n && in_slot_free)
        begin
            if (pending_rows_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                r = pending_rows_q.pop_front();
                glyph_bits <= r.bits;
                row_index <= r.row;
                cell_x <= r.cx;
                cell_y <= r.cy;
                color <= r.color;
                in_valid <= 1'b1;
                in_slot_free = 1'b0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        pixel_write_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixel_writes_q.size() == 0)
            begin
                $display("%0t: unexpected write transaction addr %h data %h last %b",
                         $time, write_addr, write_data, last_write);
                fails++;
            end
            else
            begin
                want = pixel_writes_q.pop_front();
                if (write_addr !== want.addr)
                begin
                    $display("%0t: write_addr expected %h actual %h",
                             $time, want.addr, write_addr);
                    fails++;
                end
                if (write_data !== want.data)
                begin
                    $display("%0t: write_data expected %h actual %h",
                             $time, want.data, write_data);
                    fails++;
                end
                if (last_write !== want.last)
                begin
                    $display("%0t: last_write expected %b actual %b",
                             $time, want.last, last_write);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        logic [ADDR_BITS-1:0] pitch_word;
        int pick;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_row(8'h00, 3'd0, 12'd0, 12'd0, 24'h000000);
        add_row(8'hff, 3'd0, 12'd0, 12'd0, 24'h000000);
        add_row(8'h80, 3'd6, 12'd4095, 12'd4095, 24'hffffff);
        add_row(8'h01, 3'd7, 12'd4095, 12'd0, 24'h123456);
        add_row(8'haa, 3'd3, 12'd100, 12'd200, 24'habcdef);
        add_row(8'h55, 3'd1, 12'd0, 12'd4095, 24'h5a5a5a);
        add_row(8'h00, 3'd6, 12'd4095, 12'd4095, 24'hffffff);
        add_row(8'h81, 3'd2, 12'd2048, 12'd1024, 24'ha5a5a5);
        add_row(8'h18, 3'd5, 12'd1, 12'd1, 24'h800001);
        wait_for_drain();

        write_register(REG_FRAME_BASE, 32'hffff_fff0);
        write_register(REG_LINE_PITCH, 32'd4096);
        add_row(8'hff, 3'd7, 12'd4095, 12'd4095, 24'hffffff);
        add_row(8'h01, 3'd0, 12'd0, 12'd0, 24'h000000);
        add_row(8'h80, 3'd6, 12'd4095, 12'd4095, 24'h7fffff);
        wait_for_drain();

        write_register(REG_FRAME_BASE, 32'h8000_0000);
        write_register(REG_LINE_PITCH, 32'hffff_e000);
        add_row(8'hff, 3'd3, 12'd12, 12'd34, 24'h0f0f0f);
        add_row(8'h0f, 3'd6, 12'd4000, 12'd7, 24'hf0f0f0);
        wait_for_drain();

        write_register(REG_FRAME_BASE, 32'hffff_ffff);
        write_register(REG_LINE_PITCH, 32'h0000_1fff);
        add_row(8'hc3, 3'd4, 12'd4094, 12'd4093, 24'h010203);
        add_row(8'hff, 3'd7, 12'd4095, 12'd4095, 24'hfedcba);
        wait_for_drain();

        write_register(REG_FRAME_BASE, 32'h0000_0000);
        write_register(REG_LINE_PITCH, 32'd1);
        add_row(8'h3c, 3'd2, 12'd7, 12'd9, 24'h445566);
        add_row(8'hff, 3'd6, 12'd4095, 12'd4095, 24'hffffff);
        wait_for_drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            pick = $urandom_range(99);
            pitch_word = $urandom;
            if (pick < 10)
                pitch_word[PITCH_BITS-1:0] = '0;
            else if (pick < 20)
                pitch_word[PITCH_BITS-1:0] = PITCH_BITS'($urandom_range(8191, 4097));
            else
                pitch_word[PITCH_BITS-1:0] = PITCH_BITS'($urandom_range(4096, 1));
            write_register(REG_FRAME_BASE, $urandom);
            write_register(REG_LINE_PITCH, pitch_word);
            calm = (phase == 2);
            for (int i = 0; i < 26; i++)
                pending_rows_q.push_back(random_row());
            if (phase == 4)
                hold_request = 1'b1;
            wait_for_drain();
            calm = 1'b0;
        end

        if (fails == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
